>>> rtl/dtsat_pkg.sv
package dtsat_pkg;

	localparam int SLOT_COUNT = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TZ = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT0 = 3'd2;

	localparam logic [1:0] SLOT_OFF = 2'd0;
	localparam logic [1:0] SLOT_BAD = 2'd1;
	localparam logic [1:0] SLOT_OK = 2'd2;

	localparam logic signed [4:0] TZ_MIN = -5'sd12;
	localparam logic signed [4:0] TZ_MAX = 5'sd14;
	localparam logic signed [17:0] SEC_PER_HOUR = 18'sd3600;
	localparam logic [31:0] WARN_GAP_MS = 32'd60000;

	// floor(x / 86400) = floor((x >> 7) * DAY_RECIP >> 35) for any 32-bit x
	localparam logic [25:0] DAY_RECIP = 26'd50903317;
	// floor(v / 100) = floor((v >> 2) * HUND_RECIP >> 17) for any 14-bit v
	localparam logic [12:0] HUND_RECIP = 13'd5243;

	typedef struct packed {
		logic [31:0] utc_seconds;
		logic        time_valid;
		logic        armed;
		logic        in_auto_mode;
		logic        mission_done;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic                  start_auto;
		logic [1:0]            start_slot;
		logic                  return_manual;
		logic [SLOT_COUNT-1:0] late_skip_mask;
		logic [SLOT_COUNT-1:0] unarmed_skip_mask;
		logic [SLOT_COUNT-1:0] busy_skip_mask;
		logic [SLOT_COUNT-1:0] invalid_warn_mask;
		logic                  session_active;
	} rsp_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [16:0] due_sec;
	} slot_dec_t;

	function automatic slot_dec_t decode_slot(input logic [13:0] v);
		slot_dec_t   d;
		logic [24:0] prod;
		logic [7:0]  hh;
		logic [13:0] hh100;
		logic [6:0]  mm;
		logic [10:0] mod;
		prod = 25'(v[13:2]) * 25'(HUND_RECIP);
		hh = prod[24:17];
		hh100 = 14'({hh, 6'b0}) + 14'({hh, 5'b0}) + 14'({hh, 2'b0});
		mm = 7'(v - hh100);
		d.st = SLOT_OK;
		d.due_sec = '0;
		if (v == '0) begin
			d.st = SLOT_OFF;
		end else if (mm >= 7'd60 || hh > 8'd24 || (hh == 8'd24 && mm != 7'd0)) begin
			d.st = SLOT_BAD;
		end else begin
			if (hh == 8'd24) begin
				hh = '0;
			end
			mod = 11'({hh, 6'b0}) - 11'({hh, 2'b0}) + 11'(mm);
			d.due_sec = 17'({mod, 6'b0}) - 17'({mod, 2'b0});
		end
		return d;
	endfunction

	function automatic logic [15:0] day_of(input logic [31:0] zone_sec);
		logic [50:0] prod;
		prod = 51'(zone_sec[31:7]) * 51'(DAY_RECIP);
		return prod[50:35];
	endfunction

endpackage

>>> rtl/daily_three_slot_auto_start_timer.sv
// Daily start scheduler with three hh.mm slots.
// Request channel: req_valid/req_stall/req_data, one tick (about 1 Hz) per
// request, carrying UTC seconds, clock-valid, armed, in-auto, mission-done
// and a millisecond counter. Response channel: rsp_valid/rsp_stall/rsp_data,
// exactly one response per request, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata write enable, time zone and the
// three slot times; write only while no request is in flight.
// Throughput: one request per cycle while the response is not stalled.
// The local day is taken at the input register through one reciprocal
// multiply; second-of-day, slot checks and all scheduler state updates
// run in the single step into the response register.
// Stall: a stalled response holds in the response register; the input
// register still takes one more request, then req_stall rises.
// Reset: clears config, session, day, fired and seen marks and warn timers;
// no valid response is presented until a request is accepted.
module daily_three_slot_auto_start_timer
	import dtsat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic        enable_q;
	logic [31:0] tz_sec_q;
	logic [13:0] slot_q [SLOT_COUNT];
	slot_dec_t   dec_q [SLOT_COUNT];

	logic        session_q;
	logic [15:0] seen_day_q;
	logic [15:0] fired_day_q [SLOT_COUNT];
	logic        seen_q [SLOT_COUNT];
	logic [31:0] warn_ms_q [SLOT_COUNT];

	logic        valid_s1;
	req_t        req_s1;
	logic [31:0] local_s1;
	logic [15:0] day_s1;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        accept;
	logic        advance;
	logic [31:0] local_in;

	logic signed [4:0]  tz_clamp;
	logic signed [17:0] tz_prod;

	logic        session_n;
	logic [15:0] seen_day_n;
	logic [15:0] fired_day_n [SLOT_COUNT];
	logic        seen_n [SLOT_COUNT];
	logic [31:0] warn_ms_n [SLOT_COUNT];
	rsp_t        rsp_n;

	assign advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept = req_valid && !req_stall;
	assign local_in = req_data.utc_seconds + tz_sec_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

	always_comb begin
		tz_clamp = $signed(cfg_wdata[4:0]);
		if (tz_clamp < TZ_MIN) begin
			tz_clamp = TZ_MIN;
		end else if (tz_clamp > TZ_MAX) begin
			tz_clamp = TZ_MAX;
		end
		tz_prod = 18'(tz_clamp) * SEC_PER_HOUR;
	end

	always_comb begin
		logic        in_auto;
		logic [16:0] sod;
		logic [31:0] day_sec;
		day_sec = 32'({day_s1, 16'b0}) + 32'({day_s1, 14'b0}) + 32'({day_s1, 12'b0})
			+ 32'({day_s1, 8'b0}) + 32'({day_s1, 7'b0});
		sod = 17'(local_s1 - day_sec);
		in_auto = req_s1.in_auto_mode;
		session_n = session_q;
		seen_day_n = seen_day_q;
		rsp_n = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			fired_day_n[i] = fired_day_q[i];
			seen_n[i] = seen_q[i];
			warn_ms_n[i] = warn_ms_q[i];
		end

		if (session_q) begin
			if (!in_auto) begin
				session_n = 1'b0;
			end else if (req_s1.mission_done) begin
				session_n = 1'b0;
				rsp_n.return_manual = 1'b1;
				in_auto = 1'b0;
			end
		end

		if (enable_q && req_s1.time_valid) begin
			if (day_s1 != seen_day_q) begin
				seen_day_n = day_s1;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					seen_n[i] = 1'b0;
				end
			end
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (dec_q[i].st == SLOT_BAD) begin
					if (req_s1.now_ms - warn_ms_q[i] >= WARN_GAP_MS) begin
						warn_ms_n[i] = req_s1.now_ms;
						rsp_n.invalid_warn_mask[i] = 1'b1;
					end
				end else if (dec_q[i].st == SLOT_OK && fired_day_q[i] != day_s1) begin
					if (sod < dec_q[i].due_sec) begin
						seen_n[i] = 1'b1;
					end else begin
						fired_day_n[i] = day_s1;
						if (!seen_n[i]) begin
							rsp_n.late_skip_mask[i] = 1'b1;
						end else if (!req_s1.armed) begin
							rsp_n.unarmed_skip_mask[i] = 1'b1;
						end else if (in_auto) begin
							rsp_n.busy_skip_mask[i] = 1'b1;
						end else begin
							rsp_n.start_auto = 1'b1;
							rsp_n.start_slot = 2'(i);
							in_auto = 1'b1;
							session_n = 1'b1;
						end
					end
				end
			end
		end
		rsp_n.session_active = session_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			tz_sec_q <= '0;
			session_q <= 1'b0;
			seen_day_q <= '0;
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
				dec_q[i] <= '{st: SLOT_OFF, due_sec: '0};
				fired_day_q[i] <= '0;
				seen_q[i] <= 1'b0;
				warn_ms_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ENABLE: enable_q <= cfg_wdata[0];
					CFG_TZ: tz_sec_q <= 32'(tz_prod);
					default: begin
					end
				endcase
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (cfg_index == CFG_IDX_W'(CFG_SLOT0 + i) && cfg_wdata != slot_q[i]) begin
						slot_q[i] <= cfg_wdata;
						dec_q[i] <= decode_slot(cfg_wdata);
						fired_day_q[i] <= '0;
						seen_q[i] <= 1'b0;
					end
				end
			end else if (advance) begin
				session_q <= session_n;
				seen_day_q <= seen_day_n;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					fired_day_q[i] <= fired_day_n[i];
					seen_q[i] <= seen_n[i];
					warn_ms_q[i] <= warn_ms_n[i];
				end
			end

			if (advance || !valid_s1) begin
				valid_s1 <= accept;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data;
			local_s1 <= local_in;
			day_s1 <= day_of(local_in);
		end
		if (advance) begin
			rsp_q <= rsp_n;
		end
	end

endmodule
